/* hw/rtl/crcfr_pkg.sv */
package crcfr_pkg;

    // Width of the payload byte counter; lengths that do not fit are rejected
    localparam int COUNT_BITS = 16;
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_ONES = 32'hffffffff;

    localparam logic [7:0] SYNC_0 = 8'ha5;
    localparam logic [7:0] SYNC_1 = 8'h5a;
    localparam logic [7:0] SYNC_2 = 8'hc3;
    localparam logic [7:0] SYNC_3 = 8'h3c;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // Header byte positions
    localparam logic [3:0] HDR_TYPE   = 4'd0;
    localparam logic [3:0] HDR_SESS_0 = 4'd1;
    localparam logic [3:0] HDR_SESS_1 = 4'd2;
    localparam logic [3:0] HDR_SESS_2 = 4'd3;
    localparam logic [3:0] HDR_SESS_3 = 4'd4;
    localparam logic [3:0] HDR_LEN_0  = 4'd5;
    localparam logic [3:0] HDR_LEN_1  = 4'd6;
    localparam logic [3:0] HDR_LEN_2  = 4'd7;
    localparam logic [3:0] HDR_LEN_3  = 4'd8;

    // Trailer byte positions
    localparam logic [1:0] CRC_POS_0 = 2'd0;
    localparam logic [1:0] CRC_POS_1 = 2'd1;
    localparam logic [1:0] CRC_POS_2 = 2'd2;
    localparam logic [1:0] CRC_POS_3 = 2'd3;

    // Result event codes
    localparam logic [2:0] EV_HDR_OK  = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_CRC_BAD = 3'd3;
    localparam logic [2:0] EV_LEN_ERR = 3'd4;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_HDR,
        CMD_HDR_OK,
        CMD_HDR_ERR,
        CMD_PAY,
        CMD_CRC,
        CMD_CRC_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] idx;
        logic [7:0] data;
    } cmd_t;

    // One byte through the reflected CRC-32, as an XOR network
    function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] sync_byte(logic [1:0] pos);
        logic [7:0] s;
        unique case (pos)
            2'd0: s = SYNC_0;
            2'd1: s = SYNC_1;
            2'd2: s = SYNC_2;
            default: s = SYNC_3;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/crcfr_front.sv */
module crcfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic                cmd_valid,
    output crcfr_pkg::cmd_t     cmd
);
    import crcfr_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CRC     = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            sync_reg, sync_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [23:0]           len_lo_reg, len_lo_next;
    logic [COUNT_BITS-1:0] pay_len_reg, pay_len_next;
    logic [15:0]           max_reg;

    logic [COUNT_BITS:0]   count_inc;
    logic [31:0]           len_full;
    logic                  len_err;
    logic [3:0]            hdr_idx;

    assign count_inc = {1'b0, count_reg} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign hdr_idx   = count_reg[3:0];
    assign len_full  = {rx_byte, len_lo_reg};
    assign len_err   = (len_full > {16'd0, max_reg}) || ({1'b0, len_full} > COUNT_MAX);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_reg <= cfg_wr_data;
        end
    end

    // Frame parser: classifies each byte and issues a command
    always_comb
    begin
        phase_next   = phase_reg;
        sync_next    = sync_reg;
        count_next   = count_reg;
        len_lo_next  = len_lo_reg;
        pay_len_next = pay_len_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = CMD_HDR;
        cmd.idx      = hdr_idx;
        cmd.data     = rx_byte;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == sync_byte(sync_reg))
                    begin
                        if (sync_reg == 2'd3)
                        begin
                            sync_next  = 2'd0;
                            phase_next = PH_HEADER;
                            count_next = '0;
                        end
                        else
                        begin
                            sync_next = sync_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        sync_next = (rx_byte == SYNC_0) ? 2'd1 : 2'd0;
                    end
                end
                PH_HEADER:
                begin
                    cmd_valid = 1'b1;
                    unique case (hdr_idx)
                        HDR_LEN_0: len_lo_next[7:0]   = rx_byte;
                        HDR_LEN_1: len_lo_next[15:8]  = rx_byte;
                        HDR_LEN_2: len_lo_next[23:16] = rx_byte;
                        default: ;
                    endcase
                    if (hdr_idx == HDR_LEN_3)
                    begin
                        count_next   = '0;
                        pay_len_next = len_full[COUNT_BITS-1:0];
                        if (len_err)
                        begin
                            cmd.kind   = CMD_HDR_ERR;
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            cmd.kind   = CMD_HDR_OK;
                            phase_next = (len_full == 32'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        count_next = count_inc[COUNT_BITS-1:0];
                    end
                end
                PH_PAYLOAD:
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = CMD_PAY;
                    if (count_inc >= {1'b0, pay_len_reg})
                    begin
                        count_next = '0;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        count_next = count_inc[COUNT_BITS-1:0];
                    end
                end
                default:
                begin
                    cmd_valid = 1'b1;
                    cmd.idx   = {2'b00, count_reg[1:0]};
                    if (count_reg[1:0] == CRC_POS_3)
                    begin
                        cmd.kind   = CMD_CRC_END;
                        count_next = '0;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        cmd.kind   = CMD_CRC;
                        count_next = count_inc[COUNT_BITS-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            sync_reg    <= 2'd0;
            count_reg   <= '0;
            len_lo_reg  <= '0;
            pay_len_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sync_reg    <= sync_next;
            count_reg   <= count_next;
            len_lo_reg  <= len_lo_next;
            pay_len_reg <= pay_len_next;
        end
    end

endmodule

/* hw/rtl/crcfr_queue.sv */
module crcfr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  crcfr_pkg::cmd_t wr_cmd,
    output logic            full,
    input  logic            rd_en,
    output crcfr_pkg::cmd_t rd_cmd,
    output logic            empty
);
    import crcfr_pkg::*;

    cmd_t                    mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   fill_reg;
    logic                      do_wr, do_rd;

    assign full   = (fill_reg == QUEUE_DEPTH[QUEUE_PTR_BITS:0]);
    assign empty  = (fill_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + (QUEUE_PTR_BITS + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - (QUEUE_PTR_BITS + 1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/crcfr_back.sv */
module crcfr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_avail,
    input  crcfr_pkg::cmd_t cmd,
    output logic            cmd_take,
    output logic            empty,
    input  logic            pop,
    output logic [2:0]      event_res,
    output logic [7:0]      frame_type,
    output logic [31:0]     session_number,
    output logic [15:0]     payload_length,
    output logic [7:0]      data_byte
);
    import crcfr_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] session_reg, session_next;
    logic [31:0] len_reg, len_next;
    logic [23:0] rcv_reg, rcv_next;

    logic        out_valid_reg;
    logic [2:0]  ev_reg;
    logic [7:0]  type_out_reg;
    logic [31:0] session_out_reg;
    logic [15:0] len_out_reg;
    logic [7:0]  data_out_reg;

    logic        has_result;
    logic [2:0]  ev;
    logic [7:0]  data_out;
    logic [31:0] crc_base, crc_upd;
    logic [15:0] len_sat;
    logic        slot_free;

    assign crc_base  = (cmd.kind == CMD_HDR && cmd.idx == HDR_TYPE) ? CRC_ONES : crc_reg;
    assign crc_upd   = crc_byte(crc_base, cmd.data);
    assign len_sat   = (len_next[31:16] != 16'd0) ? 16'hffff : len_next[15:0];
    assign slot_free = !out_valid_reg || pop;
    assign cmd_take  = cmd_avail && (!has_result || slot_free);

    // Command execution: CRC, header fields, trailer compare
    always_comb
    begin
        crc_next     = crc_reg;
        type_next    = type_reg;
        session_next = session_reg;
        len_next     = len_reg;
        rcv_next     = rcv_reg;
        has_result   = 1'b0;
        ev           = EV_HDR_OK;
        data_out     = 8'd0;
        unique case (cmd.kind)
            CMD_HDR:
            begin
                crc_next = crc_upd;
                unique case (cmd.idx)
                    HDR_TYPE:   type_next           = cmd.data;
                    HDR_SESS_0: session_next[7:0]   = cmd.data;
                    HDR_SESS_1: session_next[15:8]  = cmd.data;
                    HDR_SESS_2: session_next[23:16] = cmd.data;
                    HDR_SESS_3: session_next[31:24] = cmd.data;
                    HDR_LEN_0:  len_next[7:0]       = cmd.data;
                    HDR_LEN_1:  len_next[15:8]      = cmd.data;
                    HDR_LEN_2:  len_next[23:16]     = cmd.data;
                    default: ;
                endcase
            end
            CMD_HDR_OK, CMD_HDR_ERR:
            begin
                crc_next   = crc_upd;
                len_next   = {cmd.data, len_reg[23:0]};
                has_result = 1'b1;
                ev         = (cmd.kind == CMD_HDR_ERR) ? EV_LEN_ERR : EV_HDR_OK;
            end
            CMD_PAY:
            begin
                crc_next   = crc_upd;
                has_result = 1'b1;
                ev         = EV_PAYLOAD;
                data_out   = cmd.data;
            end
            CMD_CRC:
            begin
                unique case (cmd.idx[1:0])
                    CRC_POS_0: rcv_next[7:0]   = cmd.data;
                    CRC_POS_1: rcv_next[15:8]  = cmd.data;
                    CRC_POS_2: rcv_next[23:16] = cmd.data;
                    default: ;
                endcase
            end
            default:
            begin
                has_result = 1'b1;
                ev = ((crc_reg ^ CRC_ONES) == {cmd.data, rcv_reg}) ? EV_GOOD : EV_CRC_BAD;
                crc_next = CRC_ONES;
            end
        endcase
    end

    // Frame stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_ONES;
            type_reg    <= '0;
            session_reg <= '0;
            len_reg     <= '0;
            rcv_reg     <= '0;
        end
        else if (cmd_take)
        begin
            crc_reg     <= crc_next;
            type_reg    <= type_next;
            session_reg <= session_next;
            len_reg     <= len_next;
            rcv_reg     <= rcv_next;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_take && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd_take && has_result)
        begin
            ev_reg          <= ev;
            type_out_reg    <= type_next;
            session_out_reg <= session_next;
            len_out_reg     <= len_sat;
            data_out_reg    <= data_out;
        end
    end

    assign empty          = !out_valid_reg;
    assign event_res      = ev_reg;
    assign frame_type     = type_out_reg;
    assign session_number = session_out_reg;
    assign payload_length = len_out_reg;
    assign data_byte      = data_out_reg;

endmodule

/* hw/rtl/crc32_frame_receiver.sv */
// Sync-word deframer with CRC-32 check, receive side.
// Input queue side: present a byte on rx_byte with push; it transfers at a
// clock edge where push is high and full is low. Result queue side: while
// empty is low the oldest result sits on event_res, frame_type,
// session_number, payload_length and data_byte; it transfers when pop is high.
// Only the last header byte, each payload byte and the last CRC byte give a
// result; sync and other header/CRC bytes give none.
// Path: a byte's command is written into the queue storage when the byte
// transfers, then the back end takes it and loads the output register; a
// result-bearing command waits in the queue while that register is full.
// Throughput: one byte per cycle, sustained while pop keeps up; the CRC update
// is a combinational XOR network in the back end.
// Stalls: when pop is held low the back end stops at the next result-bearing
// command, the 4-entry command queue fills, then full rises.
// cfg_wr_en/cfg_wr_data write max_payload (reset 1024); write only when idle.
// Reset: hunting for sync, queues empty, CRC preset to all ones.
module crc32_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic [7:0]  frame_type,
    output logic [31:0] session_number,
    output logic [15:0] payload_length,
    output logic [7:0]  data_byte
);
    import crcfr_pkg::*;

    logic byte_valid;
    logic cmd_valid;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic q_empty;
    logic cmd_take;

    assign byte_valid = push && !full;

    crcfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_in)
    );

    crcfr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_valid),
        .wr_cmd (cmd_in),
        .full   (full),
        .rd_en  (cmd_take),
        .rd_cmd (cmd_out),
        .empty  (q_empty)
    );

    crcfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_avail      (!q_empty),
        .cmd            (cmd_out),
        .cmd_take       (cmd_take),
        .empty          (empty),
        .pop            (pop),
        .event_res      (event_res),
        .frame_type     (frame_type),
        .session_number (session_number),
        .payload_length (payload_length),
        .data_byte      (data_byte)
    );

endmodule

/* hw/rtl/crcfr_checker.sv */
module crcfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  event_res,
    input logic [15:0] payload_length,
    input logic [7:0]  data_byte
);
    import crcfr_pkg::*;

    // Only defined event codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_res <= EV_LEN_ERR))
        else $error("undefined event code");

    // data_byte is zero except for payload transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res != EV_PAYLOAD) |-> (data_byte == 8'd0))
        else $error("data_byte set on non-payload event");

    // A payload byte only follows a header with nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res == EV_PAYLOAD) |-> (payload_length != 16'd0))
        else $error("payload byte with zero length");

    // A waiting result holds until it is popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_res) && $stable(data_byte)))
        else $error("result changed while stalled");

endmodule

bind crc32_frame_receiver crcfr_checker u_chk (.*);
